FILE: hw/rtl/nfls_pkg.sv
// shared types and constants of the nearest-four light selector
package nfls_pkg;

    localparam int INDEX_W     = 8;
    localparam int OUT_SLOTS   = 4;
    localparam int COUNT_W     = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [INDEX_W-1:0] EMPTY_INDEX = 8'hFF;

    // per-light control travelling from front to back
    typedef struct packed {
        logic                last;
        logic                hit;
        logic [INDEX_W-1:0]  index;
    } light_tag_t;

endpackage

FILE: hw/rtl/nfls_front.sv
// front end: numbers point lights and computes squared distance against range
module nfls_front #(
    parameter int MAX_LIGHTS = 128,
    parameter int COORD_BITS = 24,
    parameter int DIST_BITS  = 2 * COORD_BITS + 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_BITS-1:0]       obj_x,
    input  logic [COORD_BITS-1:0]       obj_y,
    input  logic [COORD_BITS-1:0]       obj_z,
    input  logic [COORD_BITS-1:0]       light_x,
    input  logic [COORD_BITS-1:0]       light_y,
    input  logic [COORD_BITS-1:0]       light_z,
    input  logic [COORD_BITS-1:0]       light_range,
    input  logic                        is_point,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [DIST_BITS-1:0]        out_dist,
    output nfls_pkg::light_tag_t        out_tag
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int RSQ_W = 2 * COORD_BITS;

    logic                       en;
    logic                       accept;
    logic                       below_limit;

    logic [nfls_pkg::INDEX_W-1:0] count_reg;
    logic [nfls_pkg::INDEX_W-1:0] count_next;

    logic signed [MAG_W-1:0]    dx;
    logic signed [MAG_W-1:0]    dy;
    logic signed [MAG_W-1:0]    dz;

    logic                       s1_valid_reg;
    logic [MAG_W-1:0]           s1_mx_reg;
    logic [MAG_W-1:0]           s1_my_reg;
    logic [MAG_W-1:0]           s1_mz_reg;
    logic [COORD_BITS-1:0]      s1_range_reg;
    nfls_pkg::light_tag_t       s1_tag_reg;

    logic                       s2_valid_reg;
    logic [SQ_W-1:0]            s2_sx_reg;
    logic [SQ_W-1:0]            s2_sy_reg;
    logic [SQ_W-1:0]            s2_sz_reg;
    logic [RSQ_W-1:0]           s2_rsq_reg;
    nfls_pkg::light_tag_t       s2_tag_reg;

    logic                       s3_valid_reg;
    logic [DIST_BITS-1:0]       s3_dist_reg;
    logic [RSQ_W-1:0]           s3_rsq_reg;
    nfls_pkg::light_tag_t       s3_tag_reg;

    // whole pipe moves together, held only when the queue is full
    assign en       = !s3_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    assign below_limit = count_reg < nfls_pkg::INDEX_W'(MAX_LIGHTS);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (last)
                count_next = '0;
            else if (is_point && below_limit)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign dx = $signed({light_x[COORD_BITS-1], light_x}) - $signed({obj_x[COORD_BITS-1], obj_x});
    assign dy = $signed({light_y[COORD_BITS-1], light_y}) - $signed({obj_y[COORD_BITS-1], obj_y});
    assign dz = $signed({light_z[COORD_BITS-1], light_z}) - $signed({obj_z[COORD_BITS-1], obj_z});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mx_reg        <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            s1_my_reg        <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            s1_mz_reg        <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
            s1_range_reg     <= light_range;
            s1_tag_reg.last  <= last;
            s1_tag_reg.hit   <= is_point && below_limit;
            s1_tag_reg.index <= count_reg;

            s2_sx_reg  <= s1_mx_reg * s1_mx_reg;
            s2_sy_reg  <= s1_my_reg * s1_my_reg;
            s2_sz_reg  <= s1_mz_reg * s1_mz_reg;
            s2_rsq_reg <= s1_range_reg * s1_range_reg;
            s2_tag_reg <= s1_tag_reg;

            s3_dist_reg <= DIST_BITS'(s2_sx_reg) + DIST_BITS'(s2_sy_reg)
                         + DIST_BITS'(s2_sz_reg);
            s3_rsq_reg  <= s2_rsq_reg;
            s3_tag_reg  <= s2_tag_reg;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign out_dist      = s3_dist_reg;
    assign out_tag.last  = s3_tag_reg.last;
    assign out_tag.index = s3_tag_reg.index;
    // light counts only when inside its range
    assign out_tag.hit   = s3_tag_reg.hit && (s3_dist_reg <= DIST_BITS'(s3_rsq_reg));

endmodule

FILE: hw/rtl/nfls_queue.sv
// short fifo decoupling distance front end from slot insertion
module nfls_queue #(
    parameter int WIDTH = 62
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]              mem_reg [nfls_pkg::QUEUE_DEPTH];
    logic [nfls_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [nfls_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [nfls_pkg::QCNT_W-1:0]   fill_reg;
    logic [nfls_pkg::QCNT_W-1:0]   fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = fill_reg != nfls_pkg::QCNT_W'(nfls_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hw/rtl/nfls_back.sv
// back end: sorted slot insertion and result register
module nfls_back #(
    parameter int SLOTS     = 4,
    parameter int DIST_BITS = 52
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [DIST_BITS-1:0]               in_dist,
    input  nfls_pkg::light_tag_t               in_tag,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [nfls_pkg::OUT_TDATA_W-1:0]   res_data
);

    localparam int IW = nfls_pkg::INDEX_W;
    localparam int CW = nfls_pkg::COUNT_W;

    logic [DIST_BITS-1:0] dist_reg [SLOTS];
    logic [IW-1:0]        idx_reg  [SLOTS];
    logic [DIST_BITS-1:0] dist_new [SLOTS];
    logic [IW-1:0]        idx_new  [SLOTS];
    logic [DIST_BITS-1:0] dist_prv [SLOTS];
    logic [IW-1:0]        idx_prv  [SLOTS];
    logic [SLOTS-1:0]     lt;
    logic [SLOTS-1:0]     prev_lt;

    logic [IW-1:0]        near [nfls_pkg::OUT_SLOTS];
    logic [CW-1:0]        found;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic [nfls_pkg::OUT_TDATA_W-1:0] res_data_reg;
    logic                 take;

    // a last transaction waits until the result register is free
    assign in_ready = !in_tag.last || !res_valid_reg || res_ready;
    assign take     = in_valid && in_ready;

    // list is sorted, so lt is set from the insertion point onwards
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            lt[i] = in_tag.hit && (in_dist < dist_reg[i]);
        prev_lt     = SLOTS'(lt << 1);
        dist_prv[0] = in_dist;
        idx_prv[0]  = in_tag.index;
        for (int i = 1; i < SLOTS; i++)
        begin
            dist_prv[i] = dist_reg[i-1];
            idx_prv[i]  = idx_reg[i-1];
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!lt[i])
            begin
                dist_new[i] = dist_reg[i];
                idx_new[i]  = idx_reg[i];
            end
            else if (prev_lt[i])
            begin
                dist_new[i] = dist_prv[i];
                idx_new[i]  = idx_prv[i];
            end
            else
            begin
                dist_new[i] = in_dist;
                idx_new[i]  = in_tag.index;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < nfls_pkg::OUT_SLOTS; k++)
        begin : g_out
            if (k < SLOTS)
            begin : g_used
                assign near[k] = idx_new[k];
            end
            else
            begin : g_empty
                assign near[k] = nfls_pkg::EMPTY_INDEX;
            end
        end
    endgenerate

    always_comb
    begin
        found = '0;
        for (int i = 0; i < nfls_pkg::OUT_SLOTS; i++)
            found = found + CW'(near[i] != nfls_pkg::EMPTY_INDEX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                dist_reg[i] <= '1;
                idx_reg[i]  <= nfls_pkg::EMPTY_INDEX;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (in_tag.last)
                begin
                    dist_reg[i] <= '1;
                    idx_reg[i]  <= nfls_pkg::EMPTY_INDEX;
                end
                else
                begin
                    dist_reg[i] <= dist_new[i];
                    idx_reg[i]  <= idx_new[i];
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take && in_tag.last)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && in_tag.last)
            res_data_reg <= nfls_pkg::OUT_TDATA_W'({found, near[3], near[2], near[1], near[0]});
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: hw/rtl/nearest_four_light_select.sv
// top level of the nearest-four light selector
//
//  port group  dir  payload
//  s_*         in   tdata: obj_x, obj_y, obj_z, light_x, light_y, light_z, light_range
//                   tuser: is_point, tlast: last
//  m_*         out  tdata: nearest0, nearest1, nearest2, nearest3, found_count
//
// one light per cycle sustained while the output takes results, set by the slot insertion
// a last light passes the three front stages and the queue, then its result is registered
// front pipe is three stages: abs difference, squares, sum and range compare
// a four-entry queue separates it from the slot list, so either side may stall
// reset empties the slots and clears the light count, no clearing pass
module nearest_four_light_select #(
    parameter int MAX_LIGHTS = 128,
    parameter int SLOTS      = 4,
    parameter int COORD_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // obj_x, obj_y, obj_z, light_x, light_y, light_z, light_range, zero pad
    input  logic [((7*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // is_point
    input  logic [0:0]                           s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // nearest0, nearest1, nearest2, nearest3, found_count, zero pad
    output logic [nfls_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DIST_BITS = 2 * COORD_BITS + 4;
    localparam int TAG_W     = $bits(nfls_pkg::light_tag_t);
    localparam int Q_W       = DIST_BITS + TAG_W;

    logic                  f_valid;
    logic                  f_ready;
    logic [DIST_BITS-1:0]  f_dist;
    nfls_pkg::light_tag_t  f_tag;

    logic                  q_valid;
    logic                  q_ready;
    logic [Q_W-1:0]        q_data;
    nfls_pkg::light_tag_t  q_tag;

    nfls_front #(
        .MAX_LIGHTS (MAX_LIGHTS),
        .COORD_BITS (COORD_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .obj_x       (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .obj_y       (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .obj_z       (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .light_x     (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .light_y     (s_tdata[4*COORD_BITS +: COORD_BITS]),
        .light_z     (s_tdata[5*COORD_BITS +: COORD_BITS]),
        .light_range (s_tdata[6*COORD_BITS +: COORD_BITS]),
        .is_point    (s_tuser[0]),
        .last        (s_tlast),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_dist    (f_dist),
        .out_tag     (f_tag)
    );

    nfls_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_tag, f_dist}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_tag = nfls_pkg::light_tag_t'(q_data[Q_W-1:DIST_BITS]);

    nfls_back #(
        .SLOTS     (SLOTS),
        .DIST_BITS (DIST_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_dist   (q_data[DIST_BITS-1:0]),
        .in_tag    (q_tag),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

endmodule

FILE: hw/rtl/nfls_checker.sv
// port-level checks for the nearest-four light selector and their binding
module nfls_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [nfls_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    logic [7:0] n3;
    logic [2:0] found;
    logic [2:0] non_empty;
    logic [7:0] pending_reg;
    logic       in_last;
    logic       out_done;

    assign n0    = m_tdata[7:0];
    assign n1    = m_tdata[15:8];
    assign n2    = m_tdata[23:16];
    assign n3    = m_tdata[31:24];
    assign found = m_tdata[34:32];

    assign non_empty = 3'(n0 != nfls_pkg::EMPTY_INDEX) + 3'(n1 != nfls_pkg::EMPTY_INDEX)
                     + 3'(n2 != nfls_pkg::EMPTY_INDEX) + 3'(n3 != nfls_pkg::EMPTY_INDEX);

    assign in_last  = s_tvalid && s_tready && s_tlast;
    assign out_done = m_tvalid && m_tready;

    // last transactions taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 8'(in_last) - 8'(out_done);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> found == non_empty)
        else $error("found count does not match filled slots");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (n0 != nfls_pkg::EMPTY_INDEX || n1 == nfls_pkg::EMPTY_INDEX)
                  && (n1 != nfls_pkg::EMPTY_INDEX || n2 == nfls_pkg::EMPTY_INDEX)
                  && (n2 != nfls_pkg::EMPTY_INDEX || n3 == nfls_pkg::EMPTY_INDEX))
        else $error("empty slot ahead of a filled one");

    a_caused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result without a last light");

endmodule

bind nearest_four_light_select nfls_checker u_nfls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/nearest_four_light_select_tb.sv
// self-checking testbench for the nearest-four light selector
module nearest_four_light_select_tb;

    localparam int COORD_W      = 24;
    localparam int LIGHT_LIMIT  = 128;
    localparam int SLOT_COUNT   = 4;
    localparam int IN_TDATA_W   = ((7*COORD_W+7)/8)*8;
    localparam int ITEM_TARGET  = 1800;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_LONG_RUNS = 3;

    localparam logic [nfls_pkg::INDEX_W-1:0] EMPTY_SLOT = nfls_pkg::EMPTY_INDEX;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] lz;
        logic [COORD_W-1:0] rng;
        logic               is_point;
        logic               last;
    } light_item_t;

    // laid out as in m_tdata, lowest field last
    typedef struct packed {
        logic [nfls_pkg::COUNT_W-1:0] cnt;
        logic [nfls_pkg::INDEX_W-1:0] n3;
        logic [nfls_pkg::INDEX_W-1:0] n2;
        logic [nfls_pkg::INDEX_W-1:0] n1;
        logic [nfls_pkg::INDEX_W-1:0] n0;
    } light_list_t;

    typedef struct packed {
        light_item_t item;
        logic        typed;
        light_list_t want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [nfls_pkg::OUT_TDATA_W-1:0] m_tdata;

    // predictor state
    logic [2*COORD_W+3:0]   slot_dist [SLOT_COUNT];
    logic [nfls_pkg::INDEX_W-1:0] slot_index [SLOT_COUNT];
    int                     lights_seen;

    light_list_t            expected_lists [$];
    directed_row_t          directed_rows [$];
    int                     mismatch_count = 0;
    int                     result_no = 0;
    int                     items_sent = 0;
    int                     long_runs = 0;
    int                     idle_cycles = 0;
    int                     ready_left = 0;

    nearest_four_light_select u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $time, result_no, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic logic [63:0] axis_square(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
        longint diff;
        diff = longint'($signed(a)) - longint'($signed(b));
        if (diff < 0)
            diff = -diff;
        return 64'(diff * diff);
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_dist[i] = '1;
            slot_index[i] = EMPTY_SLOT;
        end
        lights_seen = 0;
    endfunction

    // updates the slot list for one light, returns 1 when a list goes out
    function automatic bit predict_nearest(input light_item_t it, output light_list_t res);
        logic [63:0] sq_dist;
        logic [63:0] reach;
        int          pos;
        int          found;
        res = '0;
        if (it.is_point && lights_seen < LIGHT_LIMIT)
        begin
            sq_dist = axis_square(it.lx, it.ox) + axis_square(it.ly, it.oy)
                    + axis_square(it.lz, it.oz);
            reach = 64'(it.rng) * 64'(it.rng);
            if (sq_dist <= reach)
            begin
                pos = SLOT_COUNT;
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (sq_dist < 64'(slot_dist[i]))
                        pos = i;
                if (pos < SLOT_COUNT)
                begin
                    for (int i = SLOT_COUNT - 1; i > pos; i--)
                    begin
                        slot_dist[i] = slot_dist[i-1];
                        slot_index[i] = slot_index[i-1];
                    end
                    slot_dist[pos] = sq_dist[2*COORD_W+3:0];
                    slot_index[pos] = nfls_pkg::INDEX_W'(lights_seen);
                end
            end
            lights_seen++;
        end
        if (!it.last)
            return 1'b0;
        found = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_index[i] != EMPTY_SLOT)
                found++;
        res = '{nfls_pkg::COUNT_W'(found), slot_index[3], slot_index[2], slot_index[1],
                slot_index[0]};
        clear_slots();
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [COORD_W-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // a typed row overrides the predicted list, the predictor still tracks state
    task automatic send_light(input light_item_t it, input int gap,
                              input bit typed = 1'b0, input light_list_t want = '0);
        light_list_t predicted;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.rng, it.lz, it.ly, it.lx, it.oz, it.oy, it.ox};
        s_tuser  <= it.is_point;
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_nearest(it, predicted))
            expected_lists.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_lists.size() > 0);
    endtask

    task automatic send_object();
        light_item_t it;
        int          mode;
        int          n;
        int          shift;
        bit          no_gaps;
        mode = $urandom_range(0, 9);
        if (mode == 9 && long_runs >= MAX_LONG_RUNS)
            mode = 0;
        no_gaps = ($urandom_range(0, 4) == 0);
        shift = $urandom_range(0, 12);
        case (mode)
            9:
            begin
                n = $urandom_range(LIGHT_LIMIT + 1, LIGHT_LIMIT + 12);
                long_runs++;
            end
            6, 7, 8: n = $urandom_range(1, 6);
            default: n = $urandom_range(1, 12);
        endcase
        if (mode == 8)
        begin
            it.ox = extreme_value();
            it.oy = extreme_value();
            it.oz = extreme_value();
        end
        else
        begin
            it.ox = COORD_W'($urandom);
            it.oy = COORD_W'($urandom);
            it.oz = COORD_W'($urandom);
        end
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                6, 7:
                begin
                    it.lx  = COORD_W'($urandom);
                    it.ly  = COORD_W'($urandom);
                    it.lz  = COORD_W'($urandom);
                    it.rng = COORD_W'($urandom);
                end
                8:
                begin
                    it.lx  = extreme_value();
                    it.ly  = extreme_value();
                    it.lz  = extreme_value();
                    it.rng = extreme_value();
                end
                default:
                begin
                    // small offsets around the object so hits and ties are common
                    it.lx  = it.ox + ((COORD_W'($urandom_range(0, 16)) - 24'd8) << shift);
                    it.ly  = it.oy + ((COORD_W'($urandom_range(0, 16)) - 24'd8) << shift);
                    it.lz  = it.oz + ((COORD_W'($urandom_range(0, 16)) - 24'd8) << shift);
                    it.rng = COORD_W'($urandom_range(0, 14)) << shift;
                end
            endcase
            it.is_point = ($urandom_range(0, 9) != 0);
            it.last = (i == n - 1);
            send_light(it, no_gaps ? 0 : gap_len());
        end
    endtask

    // receiver: runs of ready, short and long stalls, and long stretches with none
    always @(posedge clk)
    begin
        int r;
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                m_tready <= 1'b1;
                ready_left <= $urandom_range(0, 7);
            end
            else if (r < 80)
            begin
                m_tready <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end
            else if (r < 90)
            begin
                m_tready <= 1'b0;
                ready_left <= $urandom_range(10, 40);
            end
            else
            begin
                m_tready <= 1'b1;
                ready_left <= $urandom_range(50, 200);
            end
        end
    end

    always @(posedge clk)
    begin
        light_list_t got;
        light_list_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[nfls_pkg::COUNT_W+4*nfls_pkg::INDEX_W-1:0];
            if (expected_lists.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_lists.pop_front();
                check_field("nearest0", got.n0, want.n0);
                check_field("nearest1", got.n1, want.n1);
                check_field("nearest2", got.n2, want.n2);
                check_field("nearest3", got.n3, want.n3);
                check_field("found_count", 8'(got.cnt), 8'(want.cnt));
            end
            result_no++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clear_slots();

        // single lights with last: empty list, zero distance, extremes, range ties
        directed_rows.push_back('{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b1},
            1'b1, '{3'd0, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT}});
        directed_rows.push_back('{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1, 1'b1},
            1'b1, '{3'd1, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, 8'd0}});
        directed_rows.push_back('{'{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
            24'h7FFFFF, 24'hFFFFFF, 1'b1, 1'b1},
            1'b1, '{3'd0, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT}});
        directed_rows.push_back('{'{24'h800000, 24'h0, 24'h0, 24'h7FFFFF, 24'h0, 24'h0,
            24'hFFFFFF, 1'b1, 1'b1},
            1'b1, '{3'd1, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, 8'd0}});
        directed_rows.push_back('{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
            24'h7FFFFF, 24'h0, 1'b1, 1'b1},
            1'b1, '{3'd1, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, 8'd0}});
        // one object: ties, an unnumbered light, an out of range light, a fifth insert
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000003, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000000, 24'h00000A, 1'b0, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000001, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000032, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000002, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'hFFFFFF, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'hFFFFFD, 24'h00000A, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h000100, 24'hFFFF00, 24'h0, 24'h000100, 24'hFFFF00,
            24'h000000, 24'h000000, 1'b1, 1'b1}, 1'b0, '0});
        // a point light then a non-point light carrying last
        directed_rows.push_back('{'{24'h0, 24'h0, 24'h0, 24'h000010, 24'h0, 24'h0,
            24'h000010, 1'b1, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b1},
            1'b1, '{3'd1, EMPTY_SLOT, EMPTY_SLOT, EMPTY_SLOT, 8'd0}});
        directed_rows.push_back('{'{24'h555555, 24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA,
            24'hAAAAAA, 24'hAAAAAA, 1'b1, 1'b1}, 1'b0, '0});
        directed_rows.push_back('{'{24'h7FFFFF, 24'h800000, 24'h0, 24'h7FFFFF, 24'h7FFFFF,
            24'h0, 24'hFFFFFF, 1'b1, 1'b1}, 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_light(directed_rows[i].item, gap_len(), directed_rows[i].typed,
                       directed_rows[i].want);
        hold_until_drained();

        for (int obj = 0; items_sent < ITEM_TARGET; obj++)
        begin
            send_object();
            if (obj % 15 == 14)
                hold_until_drained();
        end
        s_tvalid <= 1'b0;

        while (expected_lists.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
